// ----- rtl/lfra_pkg.sv -----
package lfra_pkg;

    localparam int ROOM_FIELD_W = 9;
    localparam int CUST_FIELD_W = 8;
    localparam int STAT_W       = 2;

    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_DEPART = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOROOM = 2'd2;

    typedef struct packed {
        logic                    mode;
        logic [CUST_FIELD_W-1:0] customer;
    } t_in_item;

    typedef struct packed {
        logic [ROOM_FIELD_W-1:0] room;
        logic [ROOM_FIELD_W-1:0] in_use;
        logic [ROOM_FIELD_W-1:0] peak;
        logic [STAT_W-1:0]       status;
    } t_out_item;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;     // capture event, start table reads
        logic resolve;  // commit state update, load result register
    } t_cmd;

endpackage

// ----- rtl/lfra_ctrl.sv -----
module lfra_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    output lfra_pkg::t_cmd o_cmd
);
    import lfra_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_BUSY = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic load;
    logic resolve;

    // Config lands only between events and wins over an input in the same cycle.
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_out_valid = r_out_valid;
    assign load        = i_in_valid && (r_state == S_IDLE) && !i_cfg_valid;
    // Commit only when the result register is free or being drained.
    assign resolve     = (r_state == S_BUSY) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (load) begin
                    n_state = S_BUSY;
                end
            end
            S_BUSY: begin
                if (resolve) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (resolve) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd.load    = load;
    assign o_cmd.resolve = resolve;

endmodule

// ----- rtl/lfra_dp.sv -----
module lfra_dp #(
    parameter int ROOMS     = 256,
    parameter int CUSTOMERS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lfra_pkg::t_cmd                      i_cmd,
    input  lfra_pkg::t_in_item                  i_in_item,
    input  logic                                i_cfg_we,
    input  logic [lfra_pkg::ROOM_FIELD_W-1:0]   i_cfg_data,
    output lfra_pkg::t_out_item                 o_out_item
);
    import lfra_pkg::*;

    localparam int RIDX_W = $clog2(ROOMS);
    localparam int CIDX_W = $clog2(CUSTOMERS);
    localparam int CNT_W  = $clog2(ROOMS + 1);
    localparam int GRP    = 16;
    localparam int GBIT_W = $clog2(GRP);
    localparam int NGRP   = (ROOMS + GRP - 1) / GRP;
    localparam int GIDX_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PAD    = NGRP * GRP;

    // Room bitmap, holder flags and counters.
    logic [ROOMS-1:0]        r_room_free;
    logic [ROOMS-1:0]        n_room_free;
    logic [CUSTOMERS-1:0]    r_holds_room;
    logic [CUSTOMERS-1:0]    n_holds_room;
    logic [CNT_W-1:0]        r_occ;
    logic [CNT_W-1:0]        n_occ;
    logic [CNT_W-1:0]        r_peak;
    logic [CNT_W-1:0]        n_peak;
    logic [ROOM_FIELD_W-1:0] r_room_count;

    // Assigned room per customer.
    logic [RIDX_W-1:0]       asg_mem [CUSTOMERS];
    logic [RIDX_W-1:0]       r_asg_rd;
    logic                    asg_we;

    // Captured event.
    logic                    r_mode;
    logic                    r_cust_ok;
    logic [CIDX_W-1:0]       r_cidx;
    logic                    r_holds;

    // Free-room search.
    logic [PAD-1:0]          avail;
    logic [NGRP-1:0]         r_grp_any;
    logic [GIDX_W-1:0]       grp_sel;
    logic [GRP-1:0]          grp_word;
    logic [GBIT_W-1:0]       bit_sel;
    logic                    found;
    logic [RIDX_W-1:0]       new_ridx;

    logic [CIDX_W-1:0]       in_cidx;
    logic                    in_cust_ok;
    logic [RIDX_W:0]         room_num;
    t_out_item               n_out;
    t_out_item               r_out;

    assign in_cidx    = CIDX_W'(i_in_item.customer);
    assign in_cust_ok = (32'(i_in_item.customer) < CUSTOMERS);

    always_comb begin
        avail = '0;
        for (int k = 0; k < ROOMS; k++) begin
            avail[k] = r_room_free[k] && (32'(r_room_count) > k);
        end
    end

    // Group summary is refreshed every cycle; a new event always sees the
    // bitmap as left by the previous one.
    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NGRP; g++) begin
            r_grp_any[g] <= |avail[g*GRP +: GRP];
        end
    end

    always_comb begin
        grp_sel = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                grp_sel = GIDX_W'(g);
            end
        end
    end

    assign found    = |r_grp_any;
    assign grp_word = avail[32'(grp_sel)*GRP +: GRP];

    always_comb begin
        bit_sel = '0;
        for (int b = GRP - 1; b >= 0; b--) begin
            if (grp_word[b]) begin
                bit_sel = GBIT_W'(b);
            end
        end
    end

    assign new_ridx = RIDX_W'({grp_sel, bit_sel});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_in_item.mode;
            r_cust_ok <= in_cust_ok;
            r_cidx    <= in_cidx;
            r_holds   <= r_holds_room[in_cidx] && in_cust_ok;
            r_asg_rd  <= asg_mem[in_cidx];
        end
        if (asg_we) begin
            asg_mem[r_cidx] <= new_ridx;
        end
    end

    always_comb begin
        n_room_free  = r_room_free;
        n_holds_room = r_holds_room;
        n_occ        = r_occ;
        n_peak       = r_peak;
        asg_we       = 1'b0;
        room_num     = '0;
        n_out.status = STAT_OK;
        if (!r_cust_ok) begin
            n_out.status = (r_mode == MODE_ARRIVE) ? STAT_FULL : STAT_NOROOM;
        end else if (r_mode == MODE_ARRIVE) begin
            if (r_holds) begin
                room_num = (RIDX_W+1)'(r_asg_rd) + 1'b1;
            end else if (!found) begin
                n_out.status = STAT_FULL;
            end else begin
                n_room_free[new_ridx] = 1'b0;
                n_holds_room[r_cidx]  = 1'b1;
                asg_we                = i_cmd.resolve;
                n_occ                 = r_occ + 1'b1;
                if (n_occ > r_peak) begin
                    n_peak = n_occ;
                end
                room_num = (RIDX_W+1)'(new_ridx) + 1'b1;
            end
        end else begin
            if (!r_holds) begin
                n_out.status = STAT_NOROOM;
            end else begin
                n_room_free[r_asg_rd] = 1'b1;
                n_holds_room[r_cidx]  = 1'b0;
                if (r_occ != '0) begin
                    n_occ = r_occ - 1'b1;
                end
                room_num = (RIDX_W+1)'(r_asg_rd) + 1'b1;
            end
        end
        n_out.room   = ROOM_FIELD_W'(room_num);
        n_out.in_use = ROOM_FIELD_W'(n_occ);
        n_out.peak   = ROOM_FIELD_W'(n_peak);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_room_free  <= '1;
            r_holds_room <= '0;
            r_occ        <= '0;
            r_peak       <= '0;
            r_room_count <= ROOM_FIELD_W'(256);
        end else begin
            if (i_cmd.resolve) begin
                r_room_free  <= n_room_free;
                r_holds_room <= n_holds_room;
                r_occ        <= n_occ;
                r_peak       <= n_peak;
            end
            if (i_cfg_we) begin
                r_room_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve) begin
            r_out <= n_out;
        end
    end

    assign o_out_item = r_out;

endmodule

// ----- rtl/lowest_free_room_allocator_unit.sv -----
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_in_item   (mode, customer)
// output    out        o_out_valid / i_out_ready  o_out_item  (room, in_use, peak, status)
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_data  (room_count)
//
// The accept edge captures an event and reads the assigned-room memory; the commit
// edge then updates the bitmap and loads the result register.
// The lowest free room comes from a registered 16-room group summary and a pick
// inside the chosen group. A result still waiting in the output register holds the
// commit until its transfer. Config is ready only between events and wins over an
// input offered in the same cycle. Reset frees every room, clears holders and counters.
module lowest_free_room_allocator_unit #(
    parameter int ROOMS     = 256,
    parameter int CUSTOMERS = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  lfra_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output lfra_pkg::t_out_item                o_out_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lfra_pkg::ROOM_FIELD_W-1:0]  i_cfg_data
);
    import lfra_pkg::*;

    t_cmd cmd;

    // Sequence accept, commit, config and result handoff.
    lfra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    // Hold room bitmap, holder table, counters and the result register.
    lfra_dp #(
        .ROOMS     (ROOMS),
        .CUSTOMERS (CUSTOMERS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_out_item (o_out_item)
    );

`ifndef SYNTHESIS
    // An accepted event blocks the input once it is in flight.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready while an event is in flight");

    // A new result appears only out of the commit cycle.
    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a committed event");

    // Error results carry no room.
    a_error_no_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != STAT_OK)) |-> (o_out_item.room == '0))
        else $error("error result carries a room number");
`endif

endmodule
